// ===== rtl/json_string_unescape_utf8_macros.svh =====
// ---------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared assertion wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

`ifndef SYNTH
`define JSU_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define JSU_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JSU_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JSU_ASSERT(label, expr)
`define JSU_IMPLY(label, ante, cons)
`define JSU_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON string unescape package
// Decoder modes, the result group type and the UTF-8 and hex helpers.
// ---------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [6:0] {
    MODE_PLAIN  = 7'b0000001,
    MODE_ESC    = 7'b0000010,
    MODE_HEX1   = 7'b0000100,
    MODE_WANTBS = 7'b0001000,
    MODE_WANTU  = 7'b0010000,
    MODE_HEX2   = 7'b0100000,
    MODE_DONE   = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
    logic            status;
    logic            error;
  } jsu_group_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic jsu_group_t utf8_group(input logic [20:0] code);
    jsu_group_t g;
    g = '0;
    if (code < 21'h80) begin
      g.count    = 3'd1;
      g.bytes[0] = code[7:0];
    end else if (code < 21'h800) begin
      g.count    = 3'd2;
      g.bytes[0] = {3'b110, code[10:6]};
      g.bytes[1] = {2'b10, code[5:0]};
    end else if (code < 21'h10000) begin
      g.count    = 3'd3;
      g.bytes[0] = {4'b1110, code[15:12]};
      g.bytes[1] = {2'b10, code[11:6]};
      g.bytes[2] = {2'b10, code[5:0]};
    end else begin
      g.count    = 3'd4;
      g.bytes[0] = {5'b11110, code[20:18]};
      g.bytes[1] = {2'b10, code[17:12]};
      g.bytes[2] = {2'b10, code[11:6]};
      g.bytes[3] = {2'b10, code[5:0]};
    end
    return g;
  endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// ---------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the escape state and turns one input beat into a group of up to four
// result bytes or a status, updating the state when the beat is accepted.
// ---------------------------------------------------------------------------
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       new_string,
  input  logic       buffer_end,
  output jsu_group_t grp
);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;

  mode_t       mode, mode_next, mode_cur;
  logic [1:0]  hex_cnt, hex_cnt_next, hex_cnt_cur;
  logic [15:0] acc, acc_next, acc_cur, acc_shift;
  logic [9:0]  hs, hs_next, hs_cur;
  logic [4:0]  hd;
  logic        fail;

  always_comb begin
    mode_cur    = new_string ? MODE_PLAIN : mode;
    hex_cnt_cur = new_string ? 2'd0 : hex_cnt;
    acc_cur     = new_string ? 16'd0 : acc;
    hs_cur      = new_string ? 10'd0 : hs;
    hd          = hex_digit(in_byte);
    acc_shift   = {acc_cur[11:0], hd[3:0]};

    mode_next    = mode_cur;
    hex_cnt_next = hex_cnt_cur;
    acc_next     = acc_cur;
    hs_next      = hs_cur;
    grp          = '0;
    fail         = 1'b0;

    if (mode_cur == MODE_DONE) begin
      grp = '0;
    end else if (buffer_end) begin
      fail = 1'b1;
    end else begin
      case (mode_cur)
        MODE_PLAIN: begin
          if (in_byte == ChQuote) begin
            mode_next    = MODE_DONE;
            hex_cnt_next = 2'd0;
            acc_next     = 16'd0;
            hs_next      = 10'd0;
            grp.count    = 3'd1;
            grp.status   = 1'b1;
          end else if (in_byte == ChBslash) begin
            mode_next = MODE_ESC;
          end else begin
            grp.count    = 3'd1;
            grp.bytes[0] = in_byte;
          end
        end
        MODE_ESC: begin
          mode_next = MODE_PLAIN;
          grp.count = 3'd1;
          case (in_byte)
            ChN:                       grp.bytes[0] = 8'h0A;
            ChR:                       grp.bytes[0] = 8'h0D;
            ChT:                       grp.bytes[0] = 8'h09;
            ChB:                       grp.bytes[0] = 8'h08;
            ChF:                       grp.bytes[0] = 8'h0C;
            ChQuote, ChBslash, ChSlash: grp.bytes[0] = in_byte;
            ChU: begin
              grp          = '0;
              mode_next    = MODE_HEX1;
              hex_cnt_next = 2'd0;
              acc_next     = 16'd0;
            end
            default: fail = 1'b1;
          endcase
        end
        MODE_WANTBS: begin
          if (in_byte != ChBslash) begin
            fail = 1'b1;
          end else begin
            mode_next = MODE_WANTU;
          end
        end
        MODE_WANTU: begin
          if (in_byte != ChU) begin
            fail = 1'b1;
          end else begin
            mode_next    = MODE_HEX2;
            hex_cnt_next = 2'd0;
            acc_next     = 16'd0;
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (!hd[4]) begin
            fail = 1'b1;
          end else if (hex_cnt_cur != 2'd3) begin
            hex_cnt_next = hex_cnt_cur + 2'd1;
            acc_next     = acc_shift;
          end else begin
            hex_cnt_next = 2'd0;
            acc_next     = 16'd0;
            if (mode_cur == MODE_HEX1) begin
              if (acc_shift[15:10] == 6'b110110) begin
                hs_next   = acc_shift[9:0];
                mode_next = MODE_WANTBS;
              end else if (acc_shift[15:10] == 6'b110111) begin
                fail = 1'b1;
              end else begin
                mode_next = MODE_PLAIN;
                grp       = utf8_group({5'd0, acc_shift});
              end
            end else begin
              if (acc_shift[15:10] != 6'b110111) begin
                fail = 1'b1;
              end else begin
                hs_next   = 10'd0;
                mode_next = MODE_PLAIN;
                grp       = utf8_group(21'h10000 + {1'b0, hs_cur, acc_shift[9:0]});
              end
            end
          end
        end
        default: mode_next = MODE_DONE;
      endcase
    end

    if (fail) begin
      mode_next    = MODE_DONE;
      hex_cnt_next = 2'd0;
      acc_next     = 16'd0;
      hs_next      = 10'd0;
      grp          = '0;
      grp.count    = 3'd1;
      grp.status   = 1'b1;
      grp.error    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      hex_cnt <= 2'd0;
      acc     <= 16'd0;
      hs      <= 10'd0;
    end else if (in_fire) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      acc     <= acc_next;
      hs      <= hs_next;
    end
  end

endmodule

// ===== rtl/jsu_emit.sv =====
// ---------------------------------------------------------------------------
// JSON string unescape result buffer
// Registers one result group and hands its bytes out one beat at a time.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_emit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  jsu_group_t grp,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_status,
  output logic       error,
  output logic       last
);

  logic [2:0]      cnt;
  logic [3:0][7:0] bytes;
  logic            status;
  logic            err;
  logic            pop;
  logic            take;

  assign out_valid = (cnt != 3'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);
  assign take      = in_fire && (grp.count != 3'd0);
  assign out_byte  = bytes[0];
  assign is_status = status;
  assign error     = err;
  assign last      = (cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (take) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes  <= grp.bytes;
      status <= grp.status;
      err    <= grp.error;
    end else if (pop) begin
      bytes <= {8'd0, bytes[3:1]};
    end
  end

  `JSU_ASSERT(a_cnt_range, cnt <= 3'd4)
  `JSU_IMPLY(a_status_single, out_valid && is_status, last && (out_byte == 8'd0))
  `JSU_IMPLY(a_error_on_status, out_valid && !is_status, !error)
  `JSU_NEXT(a_drain_step, pop && (cnt > 3'd1), cnt == $past(cnt) - 3'd1)
  `JSU_IMPLY(a_load_when_free, take, can_load)

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Timing: results of an accepted beat appear in the cycle after it is accepted.
// Throughput: one input beat per cycle when each causes at most one result and out_ready
// is high; a beat decoding to several UTF-8 bytes holds the output until its last one leaves.
// The single-entry result buffer sets the rate; the next beat is taken as its last byte leaves.
// Reset: synchronous, active high; selects plain text mode and empties the buffer.
// ---------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes the body of a JSON string, byte by byte, into UTF-8 plus a status.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       new_string,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_status,
  output logic       error,
  output logic       last
);

  jsu_group_t grp;
  logic       can_load;
  logic       in_fire;

  assign in_ready = can_load;
  assign in_fire  = in_valid && can_load;

  jsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_byte    (in_byte),
    .new_string (new_string),
    .buffer_end (buffer_end),
    .grp        (grp)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_status (is_status),
    .error     (error),
    .last      (last)
  );

endmodule
